### rtl/i2cms_pkg.sv
package i2cms_pkg;

   // Opcodes of an input item.
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Transfer modes.
   localparam logic [1:0] MODE_PTR8    = 2'd0;
   localparam logic [1:0] MODE_PTR16   = 2'd1;
   localparam logic [1:0] MODE_RDONLY  = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   // Request status codes.
   localparam logic [1:0] REQ_OK      = 2'd0;
   localparam logic [1:0] REQ_BUSY    = 2'd1;
   localparam logic [1:0] REQ_BADMODE = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_NACK    = 2'd1;
   localparam logic [1:0] ERR_ARBLOST = 2'd2;
   localparam logic [1:0] ERR_BUS     = 2'd3;

   // Byte engine status codes.
   localparam logic [7:0] ST_BUS_ERROR = 8'h00;
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_SLAR_NACK = 8'h48;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;

   // Configuration register indexes.
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_TRANSFER_MODE = 1'b1;

   // Transfer phase, one-hot.
   typedef enum logic [4:0] {
      PH_NONE = 5'b00001,
      PH_WR   = 5'b00010,
      PH_RD   = 5'b00100,
      PH_WR16 = 5'b01000,
      PH_RD16 = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] byte_count;
      logic [15:0] location;
      logic        has_buffer;
      logic [7:0]  status_code;
      logic [7:0]  rx_byte;
      logic [7:0]  next_tx_byte;
   } item_type;

   typedef struct packed {
      logic [1:0] request_status;
      logic       start_cond;
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       ack_set;
      logic       ack_clear;
      logic       stop_cond;
      logic       start_clear;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       done_res;
      logic [1:0] error_code;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic        idle_flag;
      logic [15:0] remaining;
      logic [15:0] pointer_value;
      logic [1:0]  last_error;
   } state_type;

   typedef struct packed {
      logic [6:0] slave_address;
      logic [1:0] transfer_mode;
   } cfg_type;

endpackage

### rtl/i2cms_if.sv
interface i2cms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] byte_count;
   logic [15:0] location;
   logic        has_buffer;
   logic [7:0]  status_code;
   logic [7:0]  rx_byte;
   logic [7:0]  next_tx_byte;

   modport source (output valid, opcode, byte_count, location, has_buffer, status_code,
                   rx_byte, next_tx_byte, input ready);
   modport sink (input valid, opcode, byte_count, location, has_buffer, status_code,
                 rx_byte, next_tx_byte, output ready);
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] request_status;
   logic       start_cond;
   logic       tx_valid;
   logic [7:0] tx_data;
   logic       ack_set;
   logic       ack_clear;
   logic       stop_cond;
   logic       start_clear;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic       done_res;
   logic [1:0] error_code;

   modport source (output valid, request_status, start_cond, tx_valid, tx_data, ack_set,
                   ack_clear, stop_cond, start_clear, rx_valid, rx_data, done_res,
                   error_code, input ready);
   modport sink (input valid, request_status, start_cond, tx_valid, tx_data, ack_set,
                 ack_clear, stop_cond, start_clear, rx_valid, rx_data, done_res,
                 error_code, output ready);
endinterface

### rtl/i2c_master_transfer_sequencer_top.sv
// An accepted item passes through the input register, then the result register,
// with one step of logic in between.
// Throughput: one item per cycle while results are taken; a stalled result lets
// one more item into the input register and then holds the input off.
// Reset (synchronous, active high) empties both registers, makes the sequencer
// idle with no count, pointer or error, and clears both configuration registers.
module i2c_master_transfer_sequencer_top
   import i2cms_pkg::*;
(
   input logic           clock,
   input logic           reset,
   i2cms_req_if.sink     req_chan,
   i2cms_rsp_if.source   rsp_chan,
   input logic           csr_we,
   input logic           csr_index,
   input logic [6:0]     csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   item_type   item_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   state_type  state_ff;
   state_type  state_in;
   logic       advance;
   logic       req_accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS: cfg_ff.slave_address <= csr_wdata;
            CSR_TRANSFER_MODE: cfg_ff.transfer_mode <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input stage moves on when the result register is empty or being taken.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   assign item_in = '{opcode:       req_chan.opcode,
                      byte_count:   req_chan.byte_count,
                      location:     req_chan.location,
                      has_buffer:   req_chan.has_buffer,
                      status_code:  req_chan.status_code,
                      rx_byte:      req_chan.rx_byte,
                      next_tx_byte: req_chan.next_tx_byte};

   // Sequencing logic for the item in the input register.
   i2cms_step u_step (
      .item     (item_ff),
      .state    (state_ff),
      .cfg      (cfg_ff),
      .result   (result_in),
      .state_nx (state_in)
   );

   // Valid bits and sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.phase          <= PH_NONE;
         state_ff.idle_flag      <= 1'b1;
         state_ff.remaining      <= '0;
         state_ff.pointer_value  <= '0;
         state_ff.last_error     <= ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.request_status = result_ff.request_status;
   assign rsp_chan.start_cond     = result_ff.start_cond;
   assign rsp_chan.tx_valid       = result_ff.tx_valid;
   assign rsp_chan.tx_data        = result_ff.tx_data;
   assign rsp_chan.ack_set        = result_ff.ack_set;
   assign rsp_chan.ack_clear      = result_ff.ack_clear;
   assign rsp_chan.stop_cond      = result_ff.stop_cond;
   assign rsp_chan.start_clear    = result_ff.start_clear;
   assign rsp_chan.rx_valid       = result_ff.rx_valid;
   assign rsp_chan.rx_data        = result_ff.rx_data;
   assign rsp_chan.done_res       = result_ff.done_res;
   assign rsp_chan.error_code     = result_ff.error_code;

   // An error is only ever reported with the end of a transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.error_code != ERR_NONE) |-> result_ff.done_res)
      else $error("error code without done");

   // A request that starts a transfer leaves the sequencer busy.
   assert property (@(posedge clock) disable iff (reset)
      advance && (item_ff.opcode != OP_STATUS) && result_in.start_cond |=> !state_ff.idle_flag)
      else $error("started transfer left sequencer idle");

   // A stalled result keeps a pending item in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_chan.ready |=> in_valid_ff && rsp_valid_ff)
      else $error("item dropped while result stalled");

endmodule

### rtl/i2cms_step.sv
module i2cms_step
   import i2cms_pkg::*;
(
   input  item_type   item,
   input  state_type  state,
   input  cfg_type    cfg,
   output result_type result,
   output state_type  state_nx
);

   logic        is_write;
   logic [15:0] rem_dec;
   logic        rem_gt1;
   logic        rem_dec_gt1;
   logic        ph_16;

   assign is_write    = (item.opcode == OP_WRITE);
   assign rem_dec     = (state.remaining != 16'd0) ? state.remaining - 16'd1
                                                   : state.remaining;
   assign rem_gt1     = (state.remaining[15:1] != 15'd0);
   assign rem_dec_gt1 = (rem_dec[15:1] != 15'd0);
   assign ph_16       = (state.phase == PH_WR16) || (state.phase == PH_RD16);

   // One step: decode the item against the current state.
   always_comb begin
      result   = '0;
      state_nx = state;
      unique case (item.opcode)
         OP_WRITE, OP_READ: begin
            // A new request is taken only while idle, with a nonzero byte count and a usable mode.
            if (!state.idle_flag) begin
               result.request_status = REQ_BUSY;
            end else if (item.byte_count == 16'd0) begin
               result.done_res = 1'b1;
            end else if (cfg.transfer_mode == MODE_INVALID ||
                         (cfg.transfer_mode == MODE_RDONLY && is_write)) begin
               result.request_status = REQ_BADMODE;
            end else begin
               unique case (cfg.transfer_mode)
                  MODE_PTR8: begin
                     state_nx.pointer_value = {item.location[7:0], 8'h00};
                     state_nx.phase         = is_write ? PH_WR : PH_RD;
                  end
                  MODE_PTR16: begin
                     state_nx.pointer_value = item.location;
                     state_nx.phase         = is_write ? PH_WR16 : PH_RD16;
                  end
                  default: begin
                     state_nx.phase = PH_NONE;
                  end
               endcase
               state_nx.remaining = item.has_buffer ? item.byte_count : 16'd0;
               state_nx.idle_flag = 1'b0;
               result.start_cond  = 1'b1;
            end
         end
         OP_STATUS: begin
            if (!state.idle_flag) begin
               unique case (item.status_code)
                  ST_START, ST_RESTART: begin
                     // Address byte: read bit set unless a pointer is still due.
                     state_nx.last_error = ERR_NONE;
                     result.tx_valid     = 1'b1;
                     result.tx_data      = {cfg.slave_address, state.phase == PH_NONE};
                     result.ack_set      = 1'b1;
                     result.start_clear  = 1'b1;
                  end
                  ST_SLAW_ACK: begin
                     result.tx_valid = 1'b1;
                     result.tx_data  = state.pointer_value[15:8];
                     result.ack_set  = 1'b1;
                  end
                  ST_DATA_ACK: begin
                     if (ph_16) begin
                        result.tx_valid = 1'b1;
                        result.tx_data  = state.pointer_value[7:0];
                        result.ack_set  = 1'b1;
                        state_nx.phase  = (state.phase == PH_RD16) ? PH_RD : PH_WR;
                     end else if (state.phase == PH_RD) begin
                        // Pointer sent: turn around with a repeated start.
                        result.ack_set    = 1'b1;
                        result.start_cond = 1'b1;
                        state_nx.phase    = PH_NONE;
                     end else if (state.remaining != 16'd0) begin
                        result.tx_valid    = 1'b1;
                        result.tx_data     = item.next_tx_byte;
                        result.ack_set     = 1'b1;
                        state_nx.remaining = state.remaining - 16'd1;
                     end else begin
                        result.ack_set      = 1'b1;
                        result.stop_cond    = 1'b1;
                        result.done_res     = 1'b1;
                        result.error_code   = ERR_NONE;
                        state_nx.last_error = ERR_NONE;
                        state_nx.idle_flag  = 1'b1;
                        state_nx.phase      = PH_NONE;
                     end
                  end
                  ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK, ST_ARB_LOST: begin
                     result.stop_cond    = 1'b1;
                     result.done_res     = 1'b1;
                     result.error_code   = (item.status_code == ST_ARB_LOST) ? ERR_ARBLOST
                                                                             : ERR_NACK;
                     state_nx.last_error = result.error_code;
                     state_nx.remaining  = 16'd0;
                     state_nx.idle_flag  = 1'b1;
                     state_nx.phase      = PH_NONE;
                  end
                  ST_SLAR_ACK: begin
                     result.ack_set   = rem_gt1;
                     result.ack_clear = !rem_gt1;
                  end
                  ST_RX_ACK: begin
                     state_nx.remaining = rem_dec;
                     result.rx_valid    = 1'b1;
                     result.rx_data     = item.rx_byte;
                     result.ack_set     = rem_dec_gt1;
                     result.ack_clear   = !rem_dec_gt1;
                  end
                  ST_RX_NACK: begin
                     // Last byte received: keep the recorded error.
                     state_nx.remaining = rem_dec;
                     result.rx_valid    = 1'b1;
                     result.rx_data     = item.rx_byte;
                     result.stop_cond   = 1'b1;
                     result.done_res    = 1'b1;
                     result.error_code  = state.last_error;
                     state_nx.idle_flag = 1'b1;
                     state_nx.phase     = PH_NONE;
                  end
                  ST_BUS_ERROR: begin
                     result.stop_cond    = 1'b1;
                     result.done_res     = 1'b1;
                     result.error_code   = ERR_BUS;
                     state_nx.last_error = ERR_BUS;
                     state_nx.idle_flag  = 1'b1;
                     state_nx.phase      = PH_NONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import i2cms_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 4;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_SLAVE_ADDRESS;
   logic [6:0] csr_wdata = '0;

   i2cms_req_if req_bus ();
   i2cms_rsp_if rsp_bus ();

   i2c_master_transfer_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be sent, and engine commands still due from the block.
   item_type   items_todo[$];
   result_type cmds_due[$];

   item_type offered_item = '0;
   logic     send_valid = 1'b0;
   logic     take_ready = 1'b0;
   int       send_gap = 0;
   int       stall_gap = 0;
   int       send_idle_pct = 0;
   int       ready_stall_pct = 0;
   logic     quiet = 1'b0;
   logic     hold_armed = 1'b0;
   int       hold_count = 0;
   logic     holding;
   int       fail_count = 0;

   assign req_bus.valid        = send_valid;
   assign req_bus.opcode       = offered_item.opcode;
   assign req_bus.byte_count   = offered_item.byte_count;
   assign req_bus.location     = offered_item.location;
   assign req_bus.has_buffer   = offered_item.has_buffer;
   assign req_bus.status_code  = offered_item.status_code;
   assign req_bus.rx_byte      = offered_item.rx_byte;
   assign req_bus.next_tx_byte = offered_item.next_tx_byte;
   assign rsp_bus.ready        = take_ready;

   // Sequencer state and register copies kept by the predictor.
   phase_type   seq_phase = PH_NONE;
   logic        seq_idle = 1'b1;
   logic [15:0] seq_left = '0;
   logic [15:0] seq_pointer = '0;
   logic [1:0]  seq_error = ERR_NONE;
   logic [6:0]  cfg_address = '0;
   logic [1:0]  cfg_mode = MODE_PTR8;

   // Ends a transfer: stop condition, done flag and the recorded error.
   function automatic result_type close_transfer(result_type r, logic [1:0] err);
      seq_error = err;
      seq_idle = 1'b1;
      seq_phase = PH_NONE;
      r.stop_cond = 1'b1;
      r.done_res = 1'b1;
      r.error_code = seq_error;
      return r;
   endfunction

   // Works out the engine command that one item causes and advances the state.
   function automatic result_type predict_command(item_type it);
      result_type r;
      logic       wr;
      r = '0;
      wr = (it.opcode == OP_WRITE);
      case (it.opcode)
         OP_WRITE, OP_READ: begin
            if (!seq_idle) begin
               r.request_status = REQ_BUSY;
            end else if (it.byte_count == 16'd0) begin
               r.done_res = 1'b1;
            end else if (cfg_mode == MODE_PTR8 || cfg_mode == MODE_PTR16 ||
                         (cfg_mode == MODE_RDONLY && !wr)) begin
               if (cfg_mode == MODE_PTR8) begin
                  seq_pointer = {it.location[7:0], 8'h00};
                  seq_phase = wr ? PH_WR : PH_RD;
               end else if (cfg_mode == MODE_PTR16) begin
                  seq_pointer = it.location;
                  seq_phase = wr ? PH_WR16 : PH_RD16;
               end else begin
                  seq_phase = PH_NONE;
               end
               seq_left = it.has_buffer ? it.byte_count : 16'd0;
               seq_idle = 1'b0;
               r.start_cond = 1'b1;
            end else begin
               r.request_status = REQ_BADMODE;
            end
         end
         OP_STATUS: begin
            if (!seq_idle) begin
               case (it.status_code)
                  ST_START, ST_RESTART: begin
                     seq_error = ERR_NONE;
                     r.tx_valid = 1'b1;
                     r.tx_data = {cfg_address, seq_phase == PH_NONE};
                     r.ack_set = 1'b1;
                     r.start_clear = 1'b1;
                  end
                  ST_SLAW_ACK: begin
                     r.tx_valid = 1'b1;
                     r.tx_data = seq_pointer[15:8];
                     r.ack_set = 1'b1;
                  end
                  ST_DATA_ACK: begin
                     if (seq_phase == PH_WR16 || seq_phase == PH_RD16) begin
                        r.tx_valid = 1'b1;
                        r.tx_data = seq_pointer[7:0];
                        r.ack_set = 1'b1;
                        seq_phase = (seq_phase == PH_RD16) ? PH_RD : PH_WR;
                     end else if (seq_phase == PH_RD) begin
                        // Pointer is out: go for the repeated start.
                        r.ack_set = 1'b1;
                        r.start_cond = 1'b1;
                        seq_phase = PH_NONE;
                     end else if (seq_left != 16'd0) begin
                        r.tx_valid = 1'b1;
                        r.tx_data = it.next_tx_byte;
                        r.ack_set = 1'b1;
                        seq_left = seq_left - 16'd1;
                     end else begin
                        r.ack_set = 1'b1;
                        r = close_transfer(r, ERR_NONE);
                     end
                  end
                  ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: begin
                     seq_left = '0;
                     r = close_transfer(r, ERR_NACK);
                  end
                  ST_ARB_LOST: begin
                     seq_left = '0;
                     r = close_transfer(r, ERR_ARBLOST);
                  end
                  ST_SLAR_ACK: begin
                     if (seq_left > 16'd1) r.ack_set = 1'b1;
                     else r.ack_clear = 1'b1;
                  end
                  ST_RX_ACK: begin
                     if (seq_left != 16'd0) seq_left = seq_left - 16'd1;
                     r.rx_valid = 1'b1;
                     r.rx_data = it.rx_byte;
                     if (seq_left > 16'd1) r.ack_set = 1'b1;
                     else r.ack_clear = 1'b1;
                  end
                  ST_RX_NACK: begin
                     // The last byte ends the transfer with whatever error is on record.
                     if (seq_left != 16'd0) seq_left = seq_left - 16'd1;
                     r.rx_valid = 1'b1;
                     r.rx_data = it.rx_byte;
                     r = close_transfer(r, seq_error);
                  end
                  ST_BUS_ERROR: begin
                     r = close_transfer(r, ERR_BUS);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic string show(result_type r);
      return $sformatf({"req=%0d start=%b tx=%b/%02h ack=%b/%b stop=%b sclr=%b ",
                        "rx=%b/%02h done=%b err=%0d"},
                       r.request_status, r.start_cond, r.tx_valid, r.tx_data, r.ack_set,
                       r.ack_clear, r.stop_cond, r.start_clear, r.rx_valid, r.rx_data,
                       r.done_res, r.error_code);
   endfunction

   // Sender: offers queued items, with random idle bursts between them.
   always @(posedge clock) begin : req_driver
      item_type next_item;
      if (reset) begin
         send_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (send_valid && req_bus.ready) cmds_due.push_back(predict_command(offered_item));
         if (!send_valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               send_valid <= 1'b0;
            end else if (!quiet && $urandom_range(99) < send_idle_pct) begin
               send_gap <= $urandom_range(9);
               send_valid <= 1'b0;
            end else if (items_todo.size() != 0) begin
               next_item = items_todo.pop_front();
               offered_item <= next_item;
               send_valid <= 1'b1;
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here once armed.
   always @(posedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
   end

   assign holding = hold_armed && (hold_count < HOLD_CYCLES);

   // Receiver: checks every accepted command against the oldest one due.
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (reset) begin
         take_ready <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_bus.valid && take_ready) begin
            got = {rsp_bus.request_status, rsp_bus.start_cond, rsp_bus.tx_valid,
                   rsp_bus.tx_data, rsp_bus.ack_set, rsp_bus.ack_clear, rsp_bus.stop_cond,
                   rsp_bus.start_clear, rsp_bus.rx_valid, rsp_bus.rx_data,
                   rsp_bus.done_res, rsp_bus.error_code};
            if (cmds_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected command: %s", show(got));
            end else begin
               want = cmds_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch: expected %s", show(want));
                     $display("          actual   %s", show(got));
                  end
               end
            end
         end
         if (holding) begin
            take_ready <= 1'b0;
         end else if (stall_gap != 0) begin
            stall_gap <= stall_gap - 1;
            take_ready <= 1'b0;
         end else if (!quiet && $urandom_range(99) < ready_stall_pct) begin
            stall_gap <= $urandom_range(9);
            take_ready <= 1'b0;
         end else begin
            take_ready <= 1'b1;
         end
      end
   end

   function automatic item_type random_item();
      item_type it;
      it.opcode = 2'($urandom_range(3));
      it.byte_count = 16'($urandom);
      it.location = 16'($urandom);
      it.has_buffer = 1'($urandom_range(1));
      it.status_code = 8'($urandom);
      it.rx_byte = 8'($urandom);
      it.next_tx_byte = 8'($urandom);
      return it;
   endfunction

   function automatic item_type make_request(logic [1:0] op, logic [15:0] count,
                                             logic [15:0] loc, logic buf_on);
      item_type it;
      it = random_item();
      it.opcode = op;
      it.byte_count = count;
      it.location = loc;
      it.has_buffer = buf_on;
      return it;
   endfunction

   function automatic item_type make_event(logic [7:0] code, logic [7:0] rx, logic [7:0] tx);
      item_type it;
      it = random_item();
      it.opcode = OP_STATUS;
      it.status_code = code;
      it.rx_byte = rx;
      it.next_tx_byte = tx;
      return it;
   endfunction

   task automatic write_reg(logic idx, logic [6:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SLAVE_ADDRESS) cfg_address = val;
      else cfg_mode = val[1:0];
   endtask

   // Waits until every item is sent and every command has come back.
   task automatic drain();
      while (items_todo.size() != 0 || send_valid || cmds_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [6:0] addr, logic [1:0] mode, int send_pct, int stall_pct);
      logic [6:0] wval;
      drain();
      write_reg(CSR_SLAVE_ADDRESS, addr);
      wval = 7'($urandom);
      wval[1:0] = mode;
      write_reg(CSR_TRANSFER_MODE, wval);
      send_idle_pct <= send_pct;
      ready_stall_pct <= stall_pct;
   endtask

   // Queues one transfer as the byte engine would report it, sometimes broken.
   task automatic add_transfer();
      logic [7:0] codes[$];
      logic [7:0] junk;
      logic [7:0] fault;
      logic [1:0] mode;
      logic       wr;
      logic       buf_on;
      logic       stop_now;
      int         n, data_len, pick, kind, cut, busy_at, junk_at, k;
      mode = cfg_mode;
      wr = (mode == MODE_RDONLY) ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
      pick = $urandom_range(99);
      buf_on = 1'b1;
      if (pick < 65) begin
         n = $urandom_range(1, 4);
      end else if (pick < 85) begin
         n = $urandom_range(5, 24);
      end else if (pick < 95) begin
         n = $urandom_range(1, 65535);
         buf_on = 1'b0;
      end else begin
         n = 0;
         buf_on = 1'($urandom_range(1));
      end
      data_len = buf_on ? n : 0;
      items_todo.push_back(make_request(wr ? OP_WRITE : OP_READ, 16'(n), 16'($urandom),
                                        buf_on));
      if (n == 0 || mode == MODE_INVALID || (mode == MODE_RDONLY && wr)) return;

      // Status codes of a clean transfer in the current mode.
      codes.push_back(ST_START);
      if (mode != MODE_RDONLY) begin
         codes.push_back(ST_SLAW_ACK);
         if (mode == MODE_PTR16) codes.push_back(ST_DATA_ACK);
      end
      if (wr) begin
         repeat (data_len + 1) codes.push_back(ST_DATA_ACK);
      end else begin
         if (mode != MODE_RDONLY) begin
            codes.push_back(ST_DATA_ACK);
            codes.push_back(ST_RESTART);
         end
         codes.push_back(ST_SLAR_ACK);
         repeat (((data_len > 1) ? data_len : 1) - 1) codes.push_back(ST_RX_ACK);
         codes.push_back(ST_RX_NACK);
      end

      // Most transfers run clean; the rest fail, stop short or skip the start.
      kind = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      cut = $urandom_range(codes.size() - 1);
      busy_at = ($urandom_range(7) == 0) ? $urandom_range(codes.size() - 1) : -1;
      junk_at = ($urandom_range(9) == 0) ? $urandom_range(codes.size() - 1) : -1;
      case ($urandom_range(4))
         0: fault = ST_SLAW_NACK;
         1: fault = ST_DATA_NACK;
         2: fault = ST_SLAR_NACK;
         3: fault = ST_ARB_LOST;
         default: fault = ST_BUS_ERROR;
      endcase
      stop_now = 1'b0;
      for (k = 0; k < codes.size() && !stop_now; k++) begin
         if (k == busy_at) begin
            items_todo.push_back(make_request(2'($urandom_range(1)), 16'($urandom),
                                              16'($urandom), 1'($urandom_range(1))));
         end
         if (k == junk_at) begin
            junk = 8'($urandom);
            if (junk[2:0] == 3'd0) junk[0] = 1'b1;
            items_todo.push_back(make_event(junk, 8'($urandom), 8'($urandom)));
         end
         if (kind == 1 && k == cut) begin
            items_todo.push_back(make_event(fault, 8'($urandom), 8'($urandom)));
            stop_now = 1'b1;
         end else if (kind == 2 && k == cut) begin
            if ($urandom_range(1)) begin
               items_todo.push_back(make_event(ST_BUS_ERROR, 8'($urandom), 8'($urandom)));
            end
            stop_now = 1'b1;
         end else if (!(kind == 3 && k == 0)) begin
            items_todo.push_back(make_event(codes[k], 8'($urandom), 8'($urandom)));
         end
      end
   endtask

   // Stray items: mostly status events with any code, now and then a request or an unused opcode.
   task automatic add_noise();
      item_type it;
      repeat ($urandom_range(1, 3)) begin
         it = random_item();
         if (it.opcode != OP_UNUSED && $urandom_range(9) != 0) it.opcode = OP_STATUS;
         items_todo.push_back(it);
         if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
            items_todo.push_back(make_event(ST_BUS_ERROR, 8'($urandom), 8'($urandom)));
         end
      end
   endtask

   task automatic random_phase(logic [6:0] addr, logic [1:0] mode, int send_pct,
                               int stall_pct, int target, logic hold_on, logic ending);
      int made, base;
      configure(addr, mode, send_pct, stall_pct);
      if (ending) quiet <= 1'b1;
      if (hold_on) hold_armed <= 1'b1;
      @(negedge clock);
      made = 0;
      while (made < target) begin
         base = items_todo.size();
         if ($urandom_range(99) < 88) begin
            add_transfer();
         end else begin
            add_noise();
         end
         made += items_todo.size() - base;
      end
   endtask

   // Stimulus: directed cases, then random phases over several settings.
   initial begin
      item_type it;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Pointer8 at the top address: stray items, zero count, a write with a
      // busy request inside it, and a read through the repeated start.
      configure(7'h7F, MODE_PTR8, 25, 25);
      @(negedge clock);
      items_todo.push_back(make_event(ST_START, 8'hFF, 8'hFF));
      it = random_item();
      it.opcode = OP_UNUSED;
      items_todo.push_back(it);
      items_todo.push_back(make_request(OP_WRITE, 16'h0000, 16'hFFFF, 1'b1));
      items_todo.push_back(make_request(OP_WRITE, 16'h0001, 16'hFFFF, 1'b1));
      items_todo.push_back(make_event(ST_START, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_SLAW_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_request(OP_READ, 16'hFFFF, 16'hFFFF, 1'b1));
      items_todo.push_back(make_event(ST_DATA_ACK, 8'h00, 8'hFF));
      items_todo.push_back(make_event(ST_DATA_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_request(OP_READ, 16'h0002, 16'h00A5, 1'b1));
      items_todo.push_back(make_event(ST_START, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_SLAW_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_DATA_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_RESTART, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_SLAR_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_RX_ACK, 8'hFF, 8'h00));
      items_todo.push_back(make_event(ST_RX_NACK, 8'h00, 8'hFF));

      // Read only: a write is refused; a read without a buffer and an unknown code.
      configure(7'h00, MODE_RDONLY, 0, 0);
      @(negedge clock);
      items_todo.push_back(make_request(OP_WRITE, 16'h0003, 16'h0000, 1'b1));
      items_todo.push_back(make_request(OP_READ, 16'hFFFF, 16'h0000, 1'b0));
      items_todo.push_back(make_event(ST_START, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_SLAR_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(8'h99, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_RX_NACK, 8'h5A, 8'h00));

      // Invalid mode refuses any request.
      configure(7'h2A, MODE_INVALID, 0, 0);
      @(negedge clock);
      items_todo.push_back(make_request(OP_READ, 16'h0001, 16'h0000, 1'b1));

      // Pointer16 write that ends on a data nack.
      configure(7'h55, MODE_PTR16, 0, 0);
      @(negedge clock);
      items_todo.push_back(make_request(OP_WRITE, 16'h0001, 16'h1234, 1'b1));
      items_todo.push_back(make_event(ST_START, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_SLAW_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_DATA_ACK, 8'h00, 8'h00));
      items_todo.push_back(make_event(ST_DATA_NACK, 8'h00, 8'h00));

      random_phase(7'h00, MODE_PTR8, 20, 20, 210, 1'b0, 1'b0);
      random_phase(7'h7F, MODE_PTR16, 40, 10, 210, 1'b1, 1'b0);
      random_phase(7'($urandom), MODE_RDONLY, 10, 50, 210, 1'b0, 1'b0);
      random_phase(7'($urandom), MODE_PTR8, 0, 0, 210, 1'b0, 1'b0);
      random_phase(7'($urandom), MODE_INVALID, 30, 30, 60, 1'b0, 1'b0);
      random_phase(7'h2A, MODE_PTR16, 60, 30, 210, 1'b0, 1'b0);
      random_phase(7'($urandom), MODE_PTR8, 30, 60, 210, 1'b0, 1'b0);
      random_phase(7'h55, 2'($urandom_range(2)), 0, 0, 210, 1'b0, 1'b1);

      drain();
      if (fail_count == 0 && cmds_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
